/* rtl/rfe_pkg.sv */
// Shared types, constants and helpers for the RF remote frame encoder.
// No dependencies; every other file imports this package.
package rfe_pkg;

   localparam int ID_BITS    = 16;
   localparam int KEY_BITS   = 7;
   localparam int TOTAL_BITS = ID_BITS + KEY_BITS;
   localparam int IDX_W      = $clog2(TOTAL_BITS + 1);
   localparam int POS_W      = (TOTAL_BITS > 1) ? $clog2(TOTAL_BITS) : 1;

   localparam int TICK_W  = 10;
   localparam int COUNT_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_TICKS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS    = 3'd4;

   localparam logic [TICK_W-1:0]  START_TICKS_RST  = 10'd525;
   localparam logic [TICK_W-1:0]  SHORT_TICKS_RST  = 10'd110;
   localparam logic [TICK_W-1:0]  LONG_TICKS_RST   = 10'd305;
   localparam logic [COUNT_W-1:0] REPEAT_COUNT_RST = 8'd181;
   localparam logic [TICK_W-1:0]  GAP_TICKS_RST    = 10'd0;

   // Request kinds
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SEND = 1'b1;

   typedef enum logic [1:0] {
      KIND_IDLE  = 2'd0,
      KIND_START = 2'd1,
      KIND_DATA  = 2'd2,
      KIND_GAP   = 2'd3
   } seg_kind_type;

   typedef struct packed {
      logic                req_type;
      logic [ID_BITS-1:0]  remote_id;
      logic [KEY_BITS-1:0] key_code;
   } req_payload_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
   } rsp_payload_type;

   typedef struct packed {
      logic [TICK_W-1:0]  start_ticks;
      logic [TICK_W-1:0]  short_ticks;
      logic [TICK_W-1:0]  long_ticks;
      logic [COUNT_W-1:0] repeat_count;
      logic [TICK_W-1:0]  gap_ticks;
   } cfg_type;

   // A zero segment length still lasts one tick.
   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

endpackage

/* rtl/rf_remote_frame_encoder.sv */
// Channel   Direction  Ports                              Content
// request   in         req_valid, req_stall, req_data      tick or send, remote id, key code
// response  out        rsp_valid, rsp_stall, rsp_data      line level, busy, accepted
// config    in         csr_wr_en, csr_index, csr_wdata     five timing/count registers
//
// One request per cycle sustained while the response is not stalled; each request goes
// to the input register, then the sequencer step into the output register (the response).
// Reset is synchronous and active high; it restores the register defaults and idles.
// A stalled response holds the output register, which in turn holds the input register.
// Depends on rfe_pkg, rfe_csr and rfe_core.
module rf_remote_frame_encoder
   import rfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   rsp_payload_type step_result;
   logic            advance;
   logic            req_take;

   rfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rfe_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   // Advance the held request when the output register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = step_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* rtl/rfe_csr.sv */
// Configuration registers of the RF remote frame encoder.
// Depends on rfe_pkg for the register indexes, reset values and cfg_type.
module rfe_csr
   import rfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_TICKS:  cfg_in.start_ticks  = csr_wdata[TICK_W-1:0];
            CSR_SHORT_TICKS:  cfg_in.short_ticks  = csr_wdata[TICK_W-1:0];
            CSR_LONG_TICKS:   cfg_in.long_ticks   = csr_wdata[TICK_W-1:0];
            CSR_REPEAT_COUNT: cfg_in.repeat_count = csr_wdata[COUNT_W-1:0];
            CSR_GAP_TICKS:    cfg_in.gap_ticks    = csr_wdata[TICK_W-1:0];
            default:          cfg_in = cfg_ff;  // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_ticks  <= START_TICKS_RST;
         cfg_ff.short_ticks  <= SHORT_TICKS_RST;
         cfg_ff.long_ticks   <= LONG_TICKS_RST;
         cfg_ff.repeat_count <= REPEAT_COUNT_RST;
         cfg_ff.gap_ticks    <= GAP_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/rfe_core.sv */
// Segment sequencer of the RF remote frame encoder: frame state and per-request step.
// Depends on rfe_pkg for types, constants and at_least_one.
module rfe_core
   import rfe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type item,
   input  cfg_type         cfg,
   output rsp_payload_type result
);

   seg_kind_type           kind_ff, kind_in;
   logic [TOTAL_BITS-1:0]  shift_ff, shift_in;
   logic [IDX_W-1:0]       bit_index_ff, bit_index_in;
   logic                   second_half_ff, second_half_in;
   logic                   phase_ff, phase_in;
   logic [TICK_W-1:0]      left_ff, left_in;
   logic [COUNT_W-1:0]     frames_ff, frames_in;
   logic                   level_ff, level_in;

   logic [IDX_W-1:0]   idx_next;
   logic [IDX_W-1:0]   pos_cur;
   logic [IDX_W-1:0]   pos_next;
   logic               cur_bit;
   logic               next_bit;
   logic [TICK_W-1:0]  left_dec;
   logic [COUNT_W-1:0] frames_dec;
   logic               phase_flip;

   assign idx_next   = bit_index_ff + IDX_W'(1);
   assign pos_cur    = IDX_W'(TOTAL_BITS - 1) - bit_index_ff;
   assign pos_next   = IDX_W'(TOTAL_BITS - 1) - idx_next;
   assign cur_bit    = (bit_index_ff < IDX_W'(TOTAL_BITS)) ?
                       shift_ff[pos_cur[POS_W-1:0]] : 1'b0;
   assign next_bit   = (idx_next < IDX_W'(TOTAL_BITS)) ?
                       shift_ff[pos_next[POS_W-1:0]] : 1'b0;
   assign left_dec   = (left_ff != '0) ? left_ff - TICK_W'(1) : left_ff;
   assign frames_dec = (frames_ff != '0) ? frames_ff - COUNT_W'(1) : frames_ff;
   assign phase_flip = ~phase_ff;

   always_comb begin
      kind_in        = kind_ff;
      shift_in       = shift_ff;
      bit_index_in   = bit_index_ff;
      second_half_in = second_half_ff;
      phase_in       = phase_ff;
      left_in        = left_ff;
      frames_in      = frames_ff;
      level_in       = level_ff;
      result         = '0;

      if (step) begin
         if (item.req_type == REQ_SEND) begin
            if (kind_ff == KIND_IDLE && cfg.repeat_count != '0) begin
               shift_in       = {item.remote_id, item.key_code};
               bit_index_in   = '0;
               second_half_in = 1'b0;
               frames_in      = cfg.repeat_count;
               kind_in        = KIND_START;
               left_in        = at_least_one(cfg.start_ticks);
               level_in       = 1'b1;
               result.accepted = 1'b1;
            end
            result.line_level = level_in;
            result.busy_res   = (kind_in != KIND_IDLE);
         end else if (kind_ff != KIND_IDLE) begin
            result.line_level = level_ff;
            result.busy_res   = 1'b1;
            left_in = left_dec;
            if (left_dec == '0) begin
               case (kind_ff)
                  KIND_START: begin
                     phase_in       = 1'b1;
                     second_half_in = 1'b0;
                     bit_index_in   = '0;
                     kind_in        = KIND_DATA;
                     level_in       = 1'b0;
                     // first bit sits at the top of the shift word
                     left_in = shift_ff[TOTAL_BITS-1] ? at_least_one(cfg.long_ticks)
                                                      : at_least_one(cfg.short_ticks);
                  end
                  KIND_DATA: begin
                     phase_in = phase_flip;
                     if (!cur_bit && !second_half_ff) begin
                        second_half_in = 1'b1;
                        left_in        = at_least_one(cfg.short_ticks);
                        level_in       = ~phase_flip;
                     end else begin
                        second_half_in = 1'b0;
                        bit_index_in   = idx_next;
                        if (idx_next < IDX_W'(TOTAL_BITS)) begin
                           left_in  = next_bit ? at_least_one(cfg.long_ticks)
                                               : at_least_one(cfg.short_ticks);
                           level_in = ~phase_flip;
                        end else begin
                           // end of frame: drop to low, count the frame off
                           phase_in  = 1'b0;
                           level_in  = 1'b0;
                           frames_in = frames_dec;
                           if (cfg.gap_ticks != '0) begin
                              kind_in = KIND_GAP;
                              left_in = cfg.gap_ticks;
                           end else if (frames_dec != '0) begin
                              kind_in  = KIND_START;
                              left_in  = at_least_one(cfg.start_ticks);
                              level_in = 1'b1;
                           end else begin
                              kind_in = KIND_IDLE;
                              left_in = '0;
                           end
                        end
                     end
                  end
                  KIND_GAP: begin
                     if (frames_ff != '0) begin
                        kind_in  = KIND_START;
                        left_in  = at_least_one(cfg.start_ticks);
                        level_in = 1'b1;
                     end else begin
                        kind_in  = KIND_IDLE;
                        left_in  = '0;
                        level_in = 1'b0;
                     end
                  end
                  default: kind_in = kind_ff;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff        <= KIND_IDLE;
         shift_ff       <= '0;
         bit_index_ff   <= '0;
         second_half_ff <= 1'b0;
         phase_ff       <= 1'b1;
         left_ff        <= '0;
         frames_ff      <= '0;
         level_ff       <= 1'b0;
      end else begin
         kind_ff        <= kind_in;
         shift_ff       <= shift_in;
         bit_index_ff   <= bit_index_in;
         second_half_ff <= second_half_in;
         phase_ff       <= phase_in;
         left_ff        <= left_in;
         frames_ff      <= frames_in;
         level_ff       <= level_in;
      end
   end

endmodule

/* tb/rf_remote_frame_encoder_checker.sv */
`timescale 1ns / 1ps
// Response checker for rf_remote_frame_encoder: tracks the transmitter state from
// accepted requests and register writes, and compares each accepted response in order.
// Depends on rfe_pkg.
module rf_remote_frame_encoder_checker
   import rfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   cfg_type               timing;
   logic [TOTAL_BITS-1:0] frame_bits;
   logic [IDX_W-1:0]      bit_pos;
   logic                  second_half;
   logic                  phase_high;
   logic                  level;
   logic [TICK_W-1:0]     seg_left;
   logic [COUNT_W-1:0]    frames_left;
   seg_kind_type          seg_kind;
   rsp_payload_type       expected_levels[$];

   function automatic logic [TICK_W-1:0] ticks_or_one(input logic [TICK_W-1:0] v);
      logic [TICK_W-1:0] r;
      r = v;
      if (v == '0) r[0] = 1'b1;
      return r;
   endfunction

   function automatic logic bit_now();
      return frame_bits[TOTAL_BITS - 1 - int'(bit_pos)];
   endfunction

   function automatic void load_bit();
      seg_kind = KIND_DATA;
      seg_left = bit_now() ? ticks_or_one(timing.long_ticks) : ticks_or_one(timing.short_ticks);
      level    = ~phase_high;
   endfunction

   function automatic void open_frame();
      if (frames_left != '0) begin
         seg_kind = KIND_START;
         seg_left = ticks_or_one(timing.start_ticks);
         level    = 1'b1;
      end else begin
         seg_kind = KIND_IDLE;
         seg_left = '0;
         level    = 1'b0;
      end
   endfunction

   function automatic void close_frame();
      phase_high = 1'b0;
      level      = 1'b0;
      if (frames_left != '0) frames_left--;
      if (timing.gap_ticks != '0) begin
         seg_kind = KIND_GAP;
         seg_left = timing.gap_ticks;
      end else begin
         open_frame();
      end
   endfunction

   function automatic void end_segment();
      logic b;
      case (seg_kind)
         KIND_START: begin
            phase_high  = 1'b1;
            second_half = 1'b0;
            bit_pos     = '0;
            load_bit();
         end
         KIND_DATA: begin
            b = bit_now();
            phase_high = ~phase_high;
            // a zero bit takes a second short segment before advancing
            if (!b && !second_half) begin
               second_half = 1'b1;
               seg_left    = ticks_or_one(timing.short_ticks);
               level       = ~phase_high;
            end else begin
               second_half = 1'b0;
               bit_pos++;
               if (int'(bit_pos) < TOTAL_BITS) load_bit();
               else close_frame();
            end
         end
         KIND_GAP: open_frame();
         default: ;
      endcase
   endfunction

   function automatic rsp_payload_type transmit_step(input req_payload_type r);
      rsp_payload_type o;
      o = '0;
      if (r.req_type == REQ_SEND) begin
         if (seg_kind == KIND_IDLE && timing.repeat_count != '0) begin
            frame_bits  = {r.remote_id, r.key_code};
            bit_pos     = '0;
            second_half = 1'b0;
            frames_left = timing.repeat_count;
            open_frame();
            o.accepted = 1'b1;
         end
         o.line_level = level;
         o.busy_res   = (seg_kind != KIND_IDLE);
      end else if (seg_kind != KIND_IDLE) begin
         o.line_level = level;
         o.busy_res   = 1'b1;
         if (seg_left != '0) seg_left--;
         if (seg_left == '0) end_segment();
      end
      return o;
   endfunction

   function automatic void write_timing(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_START_TICKS:  timing.start_ticks  = d[TICK_W-1:0];
         CSR_SHORT_TICKS:  timing.short_ticks  = d[TICK_W-1:0];
         CSR_LONG_TICKS:   timing.long_ticks   = d[TICK_W-1:0];
         CSR_REPEAT_COUNT: timing.repeat_count = d[COUNT_W-1:0];
         CSR_GAP_TICKS:    timing.gap_ticks    = d[TICK_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %b, actual %b", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         timing      = '{START_TICKS_RST, SHORT_TICKS_RST, LONG_TICKS_RST,
                         REPEAT_COUNT_RST, GAP_TICKS_RST};
         frame_bits  = '0;
         bit_pos     = '0;
         second_half = 1'b0;
         phase_high  = 1'b1;
         level       = 1'b0;
         seg_left    = '0;
         frames_left = '0;
         seg_kind    = KIND_IDLE;
         expected_levels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               fail_count++;
               $display("%0t: response with no request outstanding: expected none, actual %b",
                        $time, rsp_data);
            end else begin
               want = expected_levels.pop_front();
               compare_field("line_level", want.line_level, rsp_data.line_level);
               compare_field("busy_res", want.busy_res, rsp_data.busy_res);
               compare_field("accepted", want.accepted, rsp_data.accepted);
            end
         end
         if (csr_wr_en) write_timing(csr_index, csr_wdata);
         if (req_valid && !req_stall) expected_levels.push_back(transmit_step(req_data));
      end
      pending <= expected_levels.size();
   end

endmodule

/* tb/rf_remote_frame_encoder_tb.sv */
`timescale 1ns / 1ps
// Top of the rf_remote_frame_encoder testbench: drives ticks, send requests and timing
// register writes, applies idling and back-pressure, and reports the verdict.
// Depends on rfe_pkg, rf_remote_frame_encoder and rf_remote_frame_encoder_checker.
module rf_remote_frame_encoder_tb;
   import rfe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int RANDOM_ITEMS   = 600;
   localparam int PHASE_ITEMS    = 130;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int      fail_count;
   int      pending;
   int      req_idle_pct = 9;
   int      rsp_idle_pct = 60;
   int      items_done   = 0;
   int      quiet_cycles = 0;
   int      hold_left    = 0;
   int      taken        = 0;
   cfg_type regs_now;

   rf_remote_frame_encoder uut (.*);

   rf_remote_frame_encoder_checker line_check (.*);

   initial forever #6 clock = ~clock;

   // Response stall: random, plus long hold-offs at a few request counts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         taken     <= 0;
      end else begin
         if (req_valid && !req_stall) taken <= taken + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (req_valid && !req_stall &&
                      (taken == 400 || taken == 800 || taken == 2600)) begin
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("rf_remote_frame_encoder_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int one_if_zero(input int v);
      return (v == 0) ? 1 : v;
   endfunction

   // Ticks needed to send a whole transmission under the current timing.
   function automatic int tx_ticks(input logic [TOTAL_BITS-1:0] bits);
      int n;
      n = one_if_zero(int'(regs_now.start_ticks));
      for (int i = 0; i < TOTAL_BITS; i++)
         n += bits[i] ? one_if_zero(int'(regs_now.long_ticks))
                      : 2 * one_if_zero(int'(regs_now.short_ticks));
      return (n + int'(regs_now.gap_ticks)) * int'(regs_now.repeat_count);
   endfunction

   function automatic logic [ID_BITS-1:0] pick_id();
      case ($urandom_range(4))
         0: return '1;
         1: return '0;
         default: return ID_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [KEY_BITS-1:0] pick_key();
      case ($urandom_range(4))
         0: return '1;
         1: return '0;
         default: return KEY_BITS'($urandom);
      endcase
   endfunction

   task automatic offer(input logic kind, input logic [ID_BITS-1:0] id,
                        input logic [KEY_BITS-1:0] key);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, remote_id: id, key_code: key};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_done++;
   endtask

   task automatic tick();
      offer(REQ_TICK, ID_BITS'($urandom), KEY_BITS'($urandom));
   endtask

   // Hold requests until every response is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c, input bit stray);
      put_reg(CSR_START_TICKS, c.start_ticks);
      put_reg(CSR_SHORT_TICKS, c.short_ticks);
      put_reg(CSR_LONG_TICKS, c.long_ticks);
      put_reg(CSR_REPEAT_COUNT, {2'($urandom), c.repeat_count});
      put_reg(CSR_GAP_TICKS, c.gap_ticks);
      // indexes past the last register must be dropped
      if (stray) put_reg(CSR_GAP_TICKS + CSR_IDX_W'($urandom_range(3, 1)), CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      regs_now = c;
   endtask

   // One send, sometimes a second one while busy, then roughly a transmission of ticks.
   task automatic burst();
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] key;
      int                  n;
      id  = pick_id();
      key = pick_key();
      offer(REQ_SEND, id, key);
      if ($urandom_range(7) == 0) offer(REQ_SEND, pick_id(), pick_key());
      n = tx_ticks({id, key});
      repeat ($urandom_range(n + 6, n * 3 / 4)) tick();
   endtask

   initial begin
      cfg_type             c;
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] key;
      int                  mode_end;
      int                  phase_end;
      regs_now = '{START_TICKS_RST, SHORT_TICKS_RST, LONG_TICKS_RST,
                   REPEAT_COUNT_RST, GAP_TICKS_RST};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // idle line reports low and not busy
      offer(REQ_TICK, '1, '1);
      offer(REQ_TICK, '0, '0);
      drain();

      // zero lengths give one-tick segments; second send lands while busy
      program_regs('{10'd0, 10'd0, 10'd0, 8'd1, 10'd0}, 1'b1);
      offer(REQ_SEND, '1, '1);
      offer(REQ_SEND, '0, '0);
      repeat (tx_ticks('1) + 1) tick();
      drain();

      // repeat count of zero refuses the send
      program_regs('{10'd2, 10'd1, 10'd3, 8'd0, 10'd1}, 1'b1);
      offer(REQ_SEND, 16'hA5C3, 7'h2A);
      tick();
      drain();

      // long start segment and gap, run to completion
      program_regs('{10'd150, 10'd0, 10'd0, 8'd1, 10'd150}, 1'b0);
      id  = pick_id();
      key = pick_key();
      offer(REQ_SEND, id, key);
      repeat (tx_ticks({id, key}) + 2) tick();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 9;
               rsp_idle_pct = 60;
            end
            1: begin
               req_idle_pct = 60;
               rsp_idle_pct = 9;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         mode_end = items_done + RANDOM_ITEMS / 3;
         while (items_done < mode_end) begin
            drain();
            c.start_ticks  = TICK_W'($urandom_range(6));
            c.short_ticks  = TICK_W'($urandom_range(4));
            c.long_ticks   = TICK_W'($urandom_range(6));
            c.repeat_count = ($urandom_range(9) == 0) ? '0 : COUNT_W'($urandom_range(3, 1));
            c.gap_ticks    = ($urandom_range(1) == 0) ? '0 : TICK_W'($urandom_range(4));
            program_regs(c, $urandom_range(3) == 0);
            phase_end = items_done + PHASE_ITEMS;
            while (items_done < phase_end) burst();
         end
      end

      // all fields at their maximum; a transmission this long is only started
      drain();
      program_regs('{10'd1023, 10'd1023, 10'd1023, 8'd255, 10'd1023}, 1'b0);
      offer(REQ_SEND, '1, '0);
      repeat (100) tick();
      offer(REQ_SEND, pick_id(), pick_key());
      drain();

      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("rf_remote_frame_encoder_tb: clean");
      end else begin
         $display("rf_remote_frame_encoder_tb: errors");
      end
      $finish;
   end

endmodule
